### rtl/segmented_sieve_marker_macros.svh
// ----------------------------------------------------------------------------
// segmented sieve marker assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_SIEVE_MARKER_MACROS_SVH
`define SEGMENTED_SIEVE_MARKER_MACROS_SVH

// checked outside reset
`define SSM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define SSM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// shared widths, codes and constants of the segmented sieve marker
// ----------------------------------------------------------------------------
package ssm_pkg;

   localparam int SSM_WINDOW_SIZE = 4096;

   localparam int VALUE_W     = 31;
   localparam int STEP_W      = 16;
   localparam int COUNT_W     = 13;
   localparam int POS_W       = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int DIV_STEPS_W = 5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_LOW  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_HIGH = 1'b1;

   localparam logic KIND_CLEAR = 1'b0;
   localparam logic KIND_MARK  = 1'b1;

   localparam logic [VALUE_W-1:0] SEGMENT_LOW_RESET  = 31'd0;
   localparam logic [VALUE_W-1:0] SEGMENT_HIGH_RESET = 31'd4095;

endpackage

### rtl/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ssm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ssm_rem.sv
// ----------------------------------------------------------------------------
// ssm_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module ssm_rem
   import ssm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [STEP_W-1:0]  divisor,
   output logic               done,
   output logic [STEP_W-1:0]  remainder
);

   localparam logic [DIV_STEPS_W-1:0] LAST_STEP = DIV_STEPS_W'(VALUE_W - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_STEPS_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]     dvd_ff, dvd_in;
   logic [STEP_W-1:0]      div_ff, div_in;
   logic [STEP_W-1:0]      rem_ff, rem_in;
   logic [STEP_W:0]        trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[VALUE_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = STEP_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[STEP_W-1:0];
         end
         dvd_in = {dvd_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### rtl/segmented_sieve_marker.sv
// ----------------------------------------------------------------------------
// segmented_sieve_marker
// bitmap of one sieve window with clear and mark-multiples items
// ----------------------------------------------------------------------------
// req channel: tuser carries the kind (clear or mark), tdata the start value
// and step. rsp channel: one transfer per item with the count of bits newly
// marked (zero for a clear). csr port writes segment low and high.
// One item is worked at a time; req_tready is high only while idle.
// Clear: the bitmap ram is swept one entry per cycle.
// Mark: a setup step, then a pass through the remainder unit when the start
// value lies below the window, then a walk over each window position visited
// (window span / step), then a drain of the last read and the posting of the result.
// The rate is set by the bitmap ram, with its one read and one write port.
// After reset the block runs a clearing pass over the whole bitmap with
// req_tready low; csr writes are taken during it.
// The result sits in an output register; a stalled receiver holds the
// block in its final state until the register empties, while a new item
// may be taken as soon as the previous result is registered.
// ----------------------------------------------------------------------------
module segmented_sieve_marker
   import ssm_pkg::*;
#(
   parameter int WINDOW_SIZE = SSM_WINDOW_SIZE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // start_value[30:0], step[46:31], zero pad
   input  logic                   req_tuser,  // kind[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // newly_marked[12:0], zero pad
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [AW-1:0]      LAST_ADDR  = AW'(WINDOW_SIZE - 1);
   localparam logic [VALUE_W-1:0] LAST_SPAN  = VALUE_W'(WINDOW_SIZE - 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_CLEAR = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic               boot_ff, boot_in;
   logic               kind_ff, kind_in;
   logic [VALUE_W-1:0] start_ff, start_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [VALUE_W-1:0] low_ff, low_in;
   logic [VALUE_W-1:0] high_ff, high_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [AW-1:0]      hi_idx_ff, hi_idx_in;
   logic [AW-1:0]      sweep_ff, sweep_in;
   logic               single_ff, single_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic [VALUE_W-1:0] span;
   logic [STEP_W-1:0]  first_off;
   logic               issue;
   logic               mark_hit;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic               ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic               ram_rd_data;

   logic               rem_start;
   logic               rem_done;
   logic [STEP_W-1:0]  rem_value;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign span       = high_ff - low_ff;
   assign first_off  = (rem_value == '0) ? '0 : step_ff - rem_value;
   assign issue      = (state_ff == ST_WALK) && !single_ff
                       && (pos_ff <= POS_W'(hi_idx_ff));
   assign mark_hit   = (state_ff == ST_WALK) && rd_pend_ff && ram_rd_data;

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      kind_in      = kind_ff;
      start_in     = start_ff;
      step_in      = step_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      pos_in       = pos_ff;
      hi_idx_in    = hi_idx_ff;
      sweep_in     = sweep_ff;
      single_in    = single_ff;
      rd_pend_in   = 1'b0;
      rd_addr_in   = rd_addr_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rem_start    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = rd_addr_ff;
      ram_wr_data  = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pos_ff[AW-1:0];

      if (csr_we) begin
         case (csr_index)
            CSR_SEGMENT_LOW:  low_in  = csr_wdata;
            CSR_SEGMENT_HIGH: high_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_tuser;
               start_in = req_tdata[VALUE_W-1:0];
               step_in  = req_tdata[VALUE_W+STEP_W-1:VALUE_W];
               sweep_in = '0;
               state_in = (req_tuser == KIND_CLEAR) ? ST_CLEAR : ST_SETUP;
            end
         end
         ST_SETUP: begin
            count_in  = '0;
            single_in = 1'b0;
            hi_idx_in = (span > LAST_SPAN) ? LAST_ADDR : span[AW-1:0];
            if (high_ff < low_ff || start_ff > high_ff) begin
               state_in = ST_DONE;
            end else if (start_ff < low_ff) begin
               if (step_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  rem_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               pos_in   = {1'b0, start_ff - low_ff};
               state_in = ST_WALK;
            end
         end
         ST_DIV: begin
            if (rem_done) begin
               pos_in   = POS_W'(first_off);
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issue) begin
               ram_rd_en  = 1'b1;
               rd_pend_in = 1'b1;
               rd_addr_in = pos_ff[AW-1:0];
               pos_in     = pos_ff + POS_W'(step_ff);
               if (step_ff == '0) begin
                  single_in = 1'b1;
               end
            end
            if (mark_hit) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = rd_addr_ff;
               ram_wr_data = 1'b0;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
            if (!issue && !rd_pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = 1'b1;
            sweep_in    = sweep_ff + 1'b1;
            count_in    = '0;
            if (sweep_ff == LAST_ADDR) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (kind_ff == KIND_MARK) ? count_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         sweep_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         single_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_ff       <= SEGMENT_LOW_RESET;
         high_ff      <= SEGMENT_HIGH_RESET;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         sweep_ff     <= sweep_in;
         rd_pend_ff   <= rd_pend_in;
         single_ff    <= single_in;
         rsp_valid_ff <= rsp_valid_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
      kind_ff     <= kind_in;
      start_ff    <= start_in;
      step_ff     <= step_in;
      pos_ff      <= pos_in;
      hi_idx_ff   <= hi_idx_in;
      rd_addr_ff  <= rd_addr_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   ssm_ram #(
      .WIDTH (1),
      .DEPTH (WINDOW_SIZE)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ssm_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (low_ff - start_ff),
      .divisor   (step_ff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-COUNT_W){1'b0}}, rsp_data_ff};

endmodule

### rtl/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker
// port level checks of the segmented sieve marker
// ----------------------------------------------------------------------------
`include "segmented_sieve_marker_macros.svh"

module ssm_checker
   import ssm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `SSM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")
   `SSM_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp data changed")
   `SSM_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready, "second req while busy")
   `SSM_ASSERT_RST(a_reset_quiet, reset |=> !rsp_tvalid && !req_tready, "active after reset")

endmodule

bind segmented_sieve_marker ssm_checker u_ssm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/tb_segmented_sieve_marker.sv
// ----------------------------------------------------------------------------
// tb_segmented_sieve_marker
// Self-checking bench for the sieve window marker. A scoreboard keeps a copy
// of the window bitmap and the segment bounds and predicts the newly marked
// count of every item. Stimulus starts with directed edge cases: bounds at the
// extremes, zero step, start above the bound, high below low and starts below
// the window. It then runs random windows, mostly clear-then-mark sequences
// with prime strides plus some noise. Both stream sides idle at random, and
// once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_segmented_sieve_marker;
   import ssm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     WIN          = SSM_WINDOW_SIZE;
   localparam int     N_ITEMS      = 290;
   localparam int     HOLD_CYCLES  = 3000;
   localparam int     TAIL_CYCLES  = 64;
   localparam longint MASK31       = 64'h7FFF_FFFF;
   localparam longint LIMIT_CYCLES = longint'(N_ITEMS + 80) * (WIN + 100) * 4 + HOLD_CYCLES;

   class sieve_scoreboard;
      bit                 unmarked [WIN];
      longint             seg_low;
      longint             seg_high;
      logic [COUNT_W-1:0] pending_counts [$];
      int                 errors;
      int                 results;

      function new();
         clear_bitmap();
         seg_low  = longint'(SEGMENT_LOW_RESET);
         seg_high = longint'(SEGMENT_HIGH_RESET);
         errors   = 0;
         results  = 0;
      endfunction

      function void clear_bitmap();
         foreach (unmarked[i]) unmarked[i] = 1'b1;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
         if (idx == CSR_SEGMENT_LOW) begin
            seg_low = longint'(val);
         end else if (idx == CSR_SEGMENT_HIGH) begin
            seg_high = longint'(val);
         end
      endfunction

      // strike one value if it falls in the window and is still unmarked
      function int strike(longint v);
         longint pos;
         if (v < seg_low) return 0;
         pos = v - seg_low;
         if (pos >= WIN) return 0;
         if (unmarked[pos]) begin
            unmarked[pos] = 1'b0;
            return 1;
         end
         return 0;
      endfunction

      function logic [COUNT_W-1:0] count_new_marks(logic [VALUE_W-1:0] start,
                                                   logic [STEP_W-1:0] step);
         longint hi;
         longint v;
         longint stride;
         longint gap;
         int     cnt;
         hi     = seg_high;
         stride = longint'(step);
         v      = longint'(start);
         cnt    = 0;
         if (hi > seg_low + WIN - 1) hi = seg_low + WIN - 1;
         if (hi < seg_low || v > hi) return '0;
         if (stride == 0) return COUNT_W'(strike(v));
         if (v < seg_low) begin
            gap = seg_low - v;
            v   = v + ((gap + stride - 1) / stride) * stride;
         end
         while (v <= hi) begin
            cnt = cnt + strike(v);
            v   = v + stride;
         end
         if (cnt > int'(COUNT_MAX)) cnt = int'(COUNT_MAX);
         return COUNT_W'(cnt);
      endfunction

      function void note_request(logic kind, logic [VALUE_W-1:0] start,
                                 logic [STEP_W-1:0] step);
         if (kind == KIND_CLEAR) begin
            clear_bitmap();
            pending_counts.push_back('0);
         end else begin
            pending_counts.push_back(count_new_marks(start, step));
         end
      endfunction

      function void check_count(logic [COUNT_W-1:0] actual);
         logic [COUNT_W-1:0] expected;
         results++;
         if (pending_counts.size() == 0) begin
            $error("newly_marked: no result expected, actual %0d", actual);
            errors++;
         end else begin
            expected = pending_counts.pop_front();
            if (actual !== expected) begin
               $error("newly_marked mismatch: expected %0d, actual %0d", expected, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // start_value[30:0], step[46:31], zero pad
   logic                   req_tuser;   // kind[0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // newly_marked[12:0], zero pad
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [VALUE_W-1:0]     csr_wdata;

   sieve_scoreboard sb = new();

   bit     idle_on    = 1'b1;
   bit     hold_armed = 1'b0;
   bit     hold_done  = 1'b0;
   int     items_sent = 0;
   int     n_clears   = 0;
   int     n_marks    = 0;
   int     n_windows  = 0;
   longint cycles     = 0;
   int     primes [25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                           53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

   segmented_sieve_marker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_CLEAR) n_clears++;
            else n_marks++;
            sb.note_request(req_tuser, req_tdata[VALUE_W-1:0], req_tdata[VALUE_W +: STEP_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_count(rsp_tdata[COUNT_W-1:0]);
         end
      end
   end

   // receiver
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_armed) begin
            hold_armed = 1'b0;
            stall      = HOLD_CYCLES;
         end else begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_item(input logic kind, input longint start, input longint step);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W-VALUE_W-STEP_W){1'b0}},
                     STEP_W'(step), VALUE_W'(start & MASK31)};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_counts.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_window(input longint lo, input longint hi);
      csr_we    <= 1'b1;
      csr_index <= CSR_SEGMENT_LOW;
      csr_wdata <= VALUE_W'(lo);
      sb.write_register(CSR_SEGMENT_LOW, VALUE_W'(lo));
      @(negedge clock);
      csr_index <= CSR_SEGMENT_HIGH;
      csr_wdata <= VALUE_W'(hi);
      sb.write_register(CSR_SEGMENT_HIGH, VALUE_W'(hi));
      @(negedge clock);
      csr_we <= 1'b0;
      n_windows++;
   endtask

   function automatic longint pick_step();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return primes[$urandom_range(0, 24)];
         6, 7:             return $urandom_range(100, WIN);
         8:                return $urandom_range(WIN + 1, 65535);
         default:          return $urandom_range(1, 3);
      endcase
   endfunction

   task automatic random_phase();
      longint lo;
      longint hi;
      longint p;
      longint s;
      int     n;
      case ($urandom_range(0, 3))
         0:       lo = $urandom_range(0, 20000);
         1:       lo = MASK31 - $urandom_range(0, 8000);
         2:       lo = $urandom & MASK31;
         default: lo = $urandom_range(0, 200000);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: hi = lo + WIN - 1;
         6:                hi = lo + $urandom_range(0, WIN - 1);
         7:                hi = lo + WIN + $urandom_range(0, 100000);
         8:                hi = (lo > 0) ? lo - $urandom_range(1, (lo > 5000) ? 5000 : lo) : 0;
         default:          hi = $urandom & MASK31;
      endcase
      if (hi > MASK31) hi = MASK31;
      set_window(lo, hi);
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
         if (!hold_done) begin
            hold_done  = 1'b1;
            hold_armed = 1'b1;
         end
         send_item(KIND_CLEAR, $urandom & MASK31, $urandom_range(0, 65535));
         n = $urandom_range(3, 8);
         repeat (n) begin
            p = pick_step();
            case ($urandom_range(0, 3))
               0:       s = (p * p <= MASK31) ? p * p : lo;
               1:       s = (lo > 0) ? lo - $urandom_range(0, (lo > 100000) ? 100000 : lo) : 0;
               2:       s = lo + $urandom_range(0, WIN - 1);
               default: s = $urandom & MASK31;
            endcase
            if (s > MASK31) s = MASK31;
            if ($urandom_range(0, 15) == 0) p = 0;
            send_item(KIND_MARK, s, p);
         end
      end else begin
         n = $urandom_range(2, 6);
         repeat (n) begin
            send_item(($urandom_range(0, 3) == 0) ? KIND_CLEAR : KIND_MARK,
                      $urandom & MASK31, $urandom_range(0, 65535));
         end
      end
      wait_idle();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_CLEAR;
      csr_we     = 1'b0;
      csr_index  = CSR_SEGMENT_LOW;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset bounds, full window
      send_item(KIND_MARK, 0, 1);
      send_item(KIND_MARK, 0, 1);
      send_item(KIND_CLEAR, 0, 0);
      send_item(KIND_MARK, 4, 2);
      send_item(KIND_MARK, 9, 3);
      send_item(KIND_MARK, 0, 0);
      send_item(KIND_MARK, 5000, 0);
      send_item(KIND_MARK, WIN, 1);
      send_item(KIND_MARK, WIN - 1, 65535);
      wait_idle();

      // window at the top of the value range, starts far below it
      set_window(MASK31 - WIN + 1, MASK31);
      send_item(KIND_MARK, 0, 65535);
      send_item(KIND_MARK, 1, 7);
      send_item(KIND_MARK, MASK31, 1);
      send_item(KIND_MARK, 3, 0);
      send_item(KIND_CLEAR, MASK31, 65535);
      send_item(KIND_MARK, 46337 * 46337, 46337);
      wait_idle();

      // high below low
      set_window(1000, 500);
      send_item(KIND_MARK, 0, 1);
      send_item(KIND_MARK, 1000, 0);
      wait_idle();

      set_window(MASK31, MASK31);
      send_item(KIND_MARK, MASK31, 3);
      send_item(KIND_MARK, 2, 65535);
      wait_idle();

      set_window(0, 0);
      send_item(KIND_CLEAR, 0, 0);
      send_item(KIND_MARK, 0, 1);
      wait_idle();

      // high bound inside the window
      set_window(100, 2000);
      send_item(KIND_CLEAR, 0, 0);
      send_item(KIND_MARK, 50, 7);
      send_item(KIND_MARK, 2000, 1);
      send_item(KIND_MARK, 101, 2);
      wait_idle();

      while (items_sent < N_ITEMS) random_phase();

      idle_on = 1'b1;
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d items (%0d clears, %0d marks) over %0d window settings",
               items_sent, n_clears, n_marks, n_windows);
      $display("checked %0d results, %0d errors, %0d cycles", sb.results, sb.errors, cycles);
      if (sb.errors == 0 && sb.pending_counts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/ssm_pkg.sv
rtl/ssm_ram.sv
rtl/ssm_rem.sv
rtl/segmented_sieve_marker.sv
rtl/ssm_checker.sv
tb/tb_segmented_sieve_marker.sv
